// ===== hdl/mct_pkg.sv =====
// Shared types and constants of the 3x3 modified census transform.
// Used by the channel interfaces and by the top level; depends on nothing.
package mct_pkg;

  // Field widths of the channels.
  localparam int PIX_W      = 8;
  localparam int CODE_W     = 9;
  localparam int IDX_W      = 20;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  // Default limits and register reset values.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;
  localparam int DIM_MIN        = 3;

  // Window sum of nine pixels, and nine times one pixel, both fit in 12 bits.
  localparam int SUM_W = 12;

  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic [CODE_W-1:0]     code_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [SUM_W-1:0]      sum_t;

  // Three horizontally adjacent pixels; element 2 is the newest (rightmost).
  typedef logic [2:0][PIX_W-1:0] triple_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

endpackage

// ===== hdl/mct_pixel_if.sv =====
// Pixel input channel: valid/ready handshake carrying one grey pixel.
// Depends on mct_pkg.
interface mct_pixel_if;
  logic          valid;
  logic          ready;
  mct_pkg::pix_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// ===== hdl/mct_census_if.sv =====
// Census result channel: valid/ready handshake carrying code, index and frame end.
// Depends on mct_pkg.
interface mct_census_if;
  logic           valid;
  logic           ready;
  mct_pkg::code_t census_code;
  mct_pkg::idx_t  center_index;
  logic           frame_last;

  modport source (output valid, output census_code, output center_index,
                  output frame_last, input ready);
  modport sink   (input valid, input census_code, input center_index,
                  input frame_last, output ready);
endinterface

// ===== hdl/mct_cfg_if.sv =====
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on mct_pkg.
interface mct_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mct_pkg::CFG_IDX_W-1:0]    index;
  mct_pkg::cfg_data_t               data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/modified_census_transform_3x3.sv =====
// Modified census transform over a 3x3 window on a raster pixel stream.
// Each code passes stage 1, stage 2 and the output register. Throughput: one pixel per
// cycle while the output is not stalled, set by the single write and two reads of the
// line memory per cycle; input ready drops in the cycle of a register write and the next.
// Reset (rst_n, synchronous): count, pipeline valids and registers go to defaults;
// the line memory is not cleared, no clearing pass is needed.
module modified_census_transform_3x3 #(
  parameter int MAX_WIDTH  = mct_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mct_pkg::DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst_n,
  mct_pixel_if.sink        in_stream,
  mct_census_if.source     out_stream,
  mct_cfg_if.sink          cfg_port
);

  // Line memory holds one pixel triple per stream position, for lags up to 2*width.
  localparam int LINE_DEPTH = 2 * MAX_WIDTH + 1;
  localparam int AW = $clog2(LINE_DEPTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int IW = (CW > mct_pkg::IDX_W) ? CW : mct_pkg::IDX_W;
  localparam int TRIPLE_W = 3 * mct_pkg::PIX_W;

  localparam int RST_W = (mct_pkg::WIDTH_RESET < MAX_WIDTH) ?
                         mct_pkg::WIDTH_RESET : MAX_WIDTH;
  localparam int RST_H = (mct_pkg::HEIGHT_RESET < MAX_HEIGHT) ?
                         mct_pkg::HEIGHT_RESET : MAX_HEIGHT;

  // Configuration registers, kept clamped, and values derived from them.
  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;
  logic [CW-1:0] last_r;
  logic [CW-1:0] span_r;
  logic          settle_r;

  // Stream position and pipeline.
  logic [CW-1:0]    count_r;
  logic [AW-1:0]    head_r;
  mct_pkg::pix_t    sh1_r, sh2_r;
  mct_pkg::triple_t rd_top_r, rd_mid_r;

  logic             s1_v_r;
  mct_pkg::triple_t s1_bot_r;
  mct_pkg::idx_t    s1_idx_r;
  logic             s1_last_r;

  logic             s2_v_r;
  mct_pkg::pix_t    s2_vals_r [9];
  mct_pkg::sum_t    s2_sum_r;
  mct_pkg::idx_t    s2_idx_r;
  logic             s2_last_r;

  logic             out_valid_r;
  mct_pkg::code_t   out_code_r;
  mct_pkg::idx_t    out_idx_r;
  logic             out_last_r;

  logic [TRIPLE_W-1:0] line_mem [LINE_DEPTH];

  logic cfg_accept;
  logic in_accept;
  logic out_free, s2_free, s1_free;
  logic emit;

  assign cfg_port.ready = 1'b1;
  assign cfg_accept     = cfg_port.valid;

  // Backpressure chain through the two pipeline stages and the output register.
  assign out_free  = !out_valid_r || out_stream.ready;
  assign s2_free   = !s2_v_r || out_free;
  assign s1_free   = !s1_v_r || s2_free;
  assign in_stream.ready = s1_free && !settle_r && !cfg_port.valid;
  assign in_accept = in_stream.valid && in_stream.ready;

  // Clamp incoming register values to the supported range.
  logic [WW-1:0] width_clamped;
  logic [HW-1:0] height_clamped;

  always_comb begin
    if (int'(cfg_port.data) < mct_pkg::DIM_MIN) begin
      width_clamped  = WW'(mct_pkg::DIM_MIN);
      height_clamped = HW'(mct_pkg::DIM_MIN);
    end else begin
      width_clamped  = (int'(cfg_port.data) > MAX_WIDTH) ? WW'(MAX_WIDTH) :
                       WW'(cfg_port.data);
      height_clamped = (int'(cfg_port.data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) :
                       HW'(cfg_port.data);
    end
  end

  // Register writes, then derived frame length and border span in the cycle after.
  logic [WW+HW-1:0] frame_size;
  assign frame_size = (WW+HW)'(width_r) * (WW+HW)'(height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(RST_W);
      height_r <= HW'(RST_H);
      last_r   <= CW'(RST_W * RST_H - 1);
      span_r   <= CW'(2 * RST_W + 2);
      settle_r <= 1'b0;
    end else begin
      settle_r <= cfg_accept;
      if (cfg_accept) begin
        unique case (cfg_port.index)
          mct_pkg::REG_IMAGE_WIDTH:  width_r  <= width_clamped;
          mct_pkg::REG_IMAGE_HEIGHT: height_r <= height_clamped;
          default: ;
        endcase
      end
      last_r <= CW'(frame_size - (WW+HW)'(1));
      span_r <= CW'({width_r, 1'b0}) + CW'(2);
    end
  end

  // Window complete and in frame: this pixel produces a code.
  assign emit = (count_r >= span_r) && (count_r <= last_r);

  // Read addresses one and two rows back, modulo the memory depth.
  logic [AW:0]   mid_diff, top_diff;
  logic [AW-1:0] mid_addr, top_addr;
  logic [IW-1:0] center_full;

  always_comb begin
    mid_diff = {1'b0, head_r} - (AW+1)'(width_r);
    top_diff = {1'b0, head_r} - (AW+1)'({width_r, 1'b0});
    mid_addr = mid_diff[AW] ? AW'(mid_diff + (AW+1)'(LINE_DEPTH)) : mid_diff[AW-1:0];
    top_addr = top_diff[AW] ? AW'(top_diff + (AW+1)'(LINE_DEPTH)) : top_diff[AW-1:0];
    center_full = IW'(count_r) - IW'(width_r) - IW'(1);
  end

  // Line memory: write the newest triple, read the triples one and two rows back.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      line_mem[head_r] <= {in_stream.pixel, sh1_r, sh2_r};
      rd_top_r <= line_mem[top_addr];
      rd_mid_r <= line_mem[mid_addr];
    end
  end

  // Stream position, pixel count and the bottom-row shift register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
    end else if (in_accept) begin
      count_r <= (count_r >= last_r) ? '0 : count_r + CW'(1);
      head_r  <= (head_r == AW'(LINE_DEPTH - 1)) ? '0 : head_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sh1_r     <= in_stream.pixel;
      sh2_r     <= sh1_r;
      s1_bot_r  <= {in_stream.pixel, sh1_r, sh2_r};
      s1_idx_r  <= center_full[mct_pkg::IDX_W-1:0];
      s1_last_r <= (count_r == last_r);
    end
  end

  // Stage 1: gather the window in code bit order and form its sum.
  mct_pkg::pix_t win_vals [9];
  mct_pkg::sum_t win_sum;

  always_comb begin
    win_vals[0] = rd_top_r[0];
    win_vals[1] = rd_top_r[1];
    win_vals[2] = rd_top_r[2];
    win_vals[3] = rd_mid_r[2];
    win_vals[4] = s1_bot_r[2];
    win_vals[5] = s1_bot_r[1];
    win_vals[6] = s1_bot_r[0];
    win_vals[7] = rd_mid_r[0];
    win_vals[8] = rd_mid_r[1];
    win_sum = '0;
    for (int i = 0; i < 9; i++) begin
      win_sum = win_sum + mct_pkg::SUM_W'(win_vals[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && s2_free && s1_v_r) begin
      s2_vals_r <= win_vals;
      s2_sum_r  <= win_sum;
      s2_idx_r  <= s1_idx_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Stage 2: compare nine times each pixel with the window sum.
  mct_pkg::code_t code_bits;
  mct_pkg::sum_t  nine_v;

  always_comb begin
    code_bits = '0;
    for (int i = 0; i < 9; i++) begin
      nine_v = (mct_pkg::SUM_W'(s2_vals_r[i]) << 3) + mct_pkg::SUM_W'(s2_vals_r[i]);
      code_bits[i] = (nine_v > s2_sum_r);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_v_r) begin
      out_code_r <= code_bits;
      out_idx_r  <= s2_idx_r;
      out_last_r <= s2_last_r;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= in_accept && emit;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_valid_r <= s2_v_r;
      end
    end
  end

  assign out_stream.valid        = out_valid_r;
  assign out_stream.census_code  = out_code_r;
  assign out_stream.center_index = out_idx_r;
  assign out_stream.frame_last   = out_last_r;

  // The memory read data must hold while stage 1 waits on a stalled stage 2.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_free |=> $stable(rd_top_r) && $stable(rd_mid_r))
    else $error("line memory read data changed under a stalled window");

  // The final pixel of a frame restarts the count.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (count_r == last_r) |=> count_r == '0)
    else $error("pixel count did not restart at frame end");

  // No pixel is taken while a register write is settling.
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_accept |=> !in_accept)
    else $error("pixel accepted right after a register write");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the 3x3 modified census transform: a directed table,
// then random pixel streams under several image sizes and flow-control patterns.
// Depends on mct_pkg, the three channel interfaces and modified_census_transform_3x3.
module tb;

  localparam int LINE_DEPTH    = 2 * mct_pkg::DEF_MAX_WIDTH + 3;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 500_000;
  localparam int N_DIRECTED    = 30;
  localparam int N_PHASES      = 6;

  // Window positions in code bit order: top-left clockwise, then center.
  localparam int WIN_ROW [9] = '{0, 0, 0, 1, 2, 2, 2, 1, 1};
  localparam int WIN_COL [9] = '{0, 1, 2, 2, 2, 1, 0, 0, 1};

  typedef struct packed {
    mct_pkg::code_t code;
    mct_pkg::idx_t  center;
    logic           last;
  } census_t;

  typedef enum logic [1:0] {ROW_PIX, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_TYPED} exp_kind_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    row_kind_t          kind;
    mct_pkg::cfg_reg_t  reg_sel;
    mct_pkg::cfg_data_t reg_data;
    mct_pkg::pix_t      pixel;
    exp_kind_t          exp_kind;
    census_t            typed;
  } stim_row_t;

  typedef struct {
    mct_pkg::cfg_data_t width;
    mct_pkg::cfg_data_t height;
    int                 items;
    idle_mode_t         idle;
    bit                 hold_off;
  } phase_t;

  logic clk;
  logic rst_n;

  mct_pixel_if  pix_if ();
  mct_census_if code_if ();
  mct_cfg_if    cfg_if ();

  modified_census_transform_3x3 u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (pix_if),
    .out_stream (code_if),
    .cfg_port   (cfg_if)
  );

  // Mirror of the block's state used to predict codes.
  mct_pkg::pix_t      pix_ring [LINE_DEPTH];
  int unsigned        ring_head;
  int unsigned        frame_pos;
  mct_pkg::cfg_data_t width_reg;
  mct_pkg::cfg_data_t height_reg;

  census_t pending_codes [$];
  int      mismatch_count;
  int      send_pct;
  int      stall_pct;
  int      cycle_count;
  int      flat_level;

  stim_row_t directed [N_DIRECTED];
  phase_t    phases [N_PHASES];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Advance the mirrored state by one pixel; returns 1 when the pixel yields a code.
  function automatic bit census_predict(input mct_pkg::pix_t p, output census_t res);
    int unsigned w, h, last, k, span, lag, sum;
    int unsigned vals [9];
    w = width_reg;
    if (w < mct_pkg::DIM_MIN) w = mct_pkg::DIM_MIN;
    else if (w > mct_pkg::DEF_MAX_WIDTH) w = mct_pkg::DEF_MAX_WIDTH;
    h = height_reg;
    if (h < mct_pkg::DIM_MIN) h = mct_pkg::DIM_MIN;
    else if (h > mct_pkg::DEF_MAX_HEIGHT) h = mct_pkg::DEF_MAX_HEIGHT;
    last = w * h - 1;
    k    = frame_pos;
    span = 2 * w + 2;
    res  = '0;
    census_predict = 1'b0;

    ring_head = (ring_head + 1) % LINE_DEPTH;
    pix_ring[ring_head] = p;

    // A window is complete once two rows and two pixels lie behind it.
    if (k >= span && k <= last) begin
      sum = 0;
      for (int i = 0; i < 9; i++) begin
        lag = span - WIN_ROW[i] * w - WIN_COL[i];
        vals[i] = pix_ring[(ring_head + LINE_DEPTH - lag) % LINE_DEPTH];
        sum += vals[i];
      end
      for (int i = 0; i < 9; i++) res.code[i] = (9 * vals[i] > sum);
      res.center = mct_pkg::idx_t'(k - w - 1);
      res.last   = (k == last);
      census_predict = 1'b1;
    end
    frame_pos = (k >= last) ? 0 : k + 1;
  endfunction

  function automatic stim_row_t px(input mct_pkg::pix_t p, input exp_kind_t ek,
                                   input mct_pkg::code_t c = '0,
                                   input mct_pkg::idx_t n = '0,
                                   input logic l = 1'b0);
    stim_row_t r;
    r.kind     = ROW_PIX;
    r.reg_sel  = mct_pkg::REG_IMAGE_WIDTH;
    r.reg_data = '0;
    r.pixel    = p;
    r.exp_kind = ek;
    r.typed    = '{code: c, center: n, last: l};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input mct_pkg::cfg_reg_t sel,
                                        input mct_pkg::cfg_data_t d);
    stim_row_t r;
    r          = px('0, EXP_NONE);
    r.kind     = ROW_CFG;
    r.reg_sel  = sel;
    r.reg_data = d;
    return r;
  endfunction

  // Wait until every expected code has come back and the pipeline has emptied.
  task automatic settle_idle();
    pix_if.valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_reg(input mct_pkg::cfg_reg_t sel, input mct_pkg::cfg_data_t d);
    settle_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= sel;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (sel == mct_pkg::REG_IMAGE_WIDTH) width_reg = d;
    else height_reg = d;
  endtask

  // One pixel transaction, with random idle cycles ahead of it.
  task automatic drive_pixel(input mct_pkg::pix_t p);
    while ($urandom_range(99) < send_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= p;
    do @(posedge clk); while (!pix_if.ready);
  endtask

  task automatic set_idle(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin send_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin send_pct = 64; stall_pct = 0;  end
      IDLE_RECV: begin send_pct = 0;  stall_pct = 64; end
      default:   begin send_pct = 13; stall_pct = 13; end
    endcase
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    code_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare every code transaction with the oldest expectation.
  always @(posedge clk) begin
    census_t want;
    if (rst_n && code_if.valid && code_if.ready) begin
      if (pending_codes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected code: expected none, actual code %h index %0d last %b",
                 $time, code_if.census_code, code_if.center_index, code_if.frame_last);
      end else begin
        want = pending_codes.pop_front();
        if (code_if.census_code !== want.code) begin
          mismatch_count++;
          $display("%0t: census_code expected %h actual %h", $time, want.code,
                   code_if.census_code);
        end
        if (code_if.center_index !== want.center) begin
          mismatch_count++;
          $display("%0t: center_index expected %0d actual %0d", $time, want.center,
                   code_if.center_index);
        end
        if (code_if.frame_last !== want.last) begin
          mismatch_count++;
          $display("%0t: frame_last expected %b actual %b", $time, want.last,
                   code_if.frame_last);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    census_t       res;
    bit            has;
    mct_pkg::pix_t p;
    int            r;

    pix_if.valid  = 1'b0;
    pix_if.pixel  = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = mct_pkg::REG_IMAGE_WIDTH;
    cfg_if.data   = '0;
    code_if.ready = 1'b0;
    rst_n         = 1'b0;
    send_pct      = 0;
    stall_pct     = 0;
    cycle_count   = 0;
    mismatch_count = 0;
    flat_level    = 128;
    width_reg     = mct_pkg::cfg_data_t'(mct_pkg::WIDTH_RESET);
    height_reg    = mct_pkg::cfg_data_t'(mct_pkg::HEIGHT_RESET);
    ring_head     = 0;
    frame_pos     = 0;
    foreach (pix_ring[i]) pix_ring[i] = '0;

    // Pixels at the reset size are all border positions. Then a width below the
    // minimum takes effect mid-frame, a zero height puts the count past the frame
    // end, and two 3x3 frames give one code each at the pixel extremes.
    directed = '{
      px(8'h00, EXP_NONE), px(8'hFF, EXP_NONE), px(8'h55, EXP_NONE),
      px(8'hAA, EXP_NONE), px(8'h0F, EXP_NONE), px(8'hF0, EXP_NONE),
      px(8'h01, EXP_NONE), px(8'h80, EXP_NONE),
      cfg_row(mct_pkg::REG_IMAGE_WIDTH, 11'd2),
      px(8'h7F, EXP_MODEL),
      cfg_row(mct_pkg::REG_IMAGE_HEIGHT, 11'd0),
      px(8'h33, EXP_NONE),
      px(8'h00, EXP_NONE), px(8'h00, EXP_NONE), px(8'h00, EXP_NONE),
      px(8'h00, EXP_NONE), px(8'hFF, EXP_NONE), px(8'h00, EXP_NONE),
      px(8'h00, EXP_NONE), px(8'h00, EXP_NONE),
      px(8'h00, EXP_TYPED, 9'h100, 20'd4, 1'b1),
      px(8'hFF, EXP_NONE), px(8'hFF, EXP_NONE), px(8'hFF, EXP_NONE),
      px(8'hFF, EXP_NONE), px(8'h00, EXP_NONE), px(8'hFF, EXP_NONE),
      px(8'hFF, EXP_NONE), px(8'hFF, EXP_NONE),
      px(8'hFF, EXP_TYPED, 9'h0FF, 20'd4, 1'b1)
    };

    // Random phases; the widest image runs well past its first code.
    phases = '{
      '{width: 11'd3,    height: 11'd3,    items: 150,  idle: IDLE_NONE, hold_off: 1'b0},
      '{width: 11'd7,    height: 11'd5,    items: 250,  idle: IDLE_SEND, hold_off: 1'b1},
      '{width: 11'd4,    height: 11'd2047, items: 200,  idle: IDLE_RECV, hold_off: 1'b0},
      '{width: 11'd150,  height: 11'd0,    items: 420,  idle: IDLE_BOTH, hold_off: 1'b0},
      '{width: 11'd3,    height: 11'd1024, items: 200,  idle: IDLE_NONE, hold_off: 1'b0},
      '{width: 11'd16,   height: 11'd3,    items: 250,  idle: IDLE_SEND, hold_off: 1'b0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed[i].kind == ROW_CFG) begin
        write_reg(directed[i].reg_sel, directed[i].reg_data);
      end else begin
        drive_pixel(directed[i].pixel);
        has = census_predict(directed[i].pixel, res);
        if (directed[i].exp_kind == EXP_TYPED) pending_codes.push_back(directed[i].typed);
        else if (directed[i].exp_kind == EXP_MODEL && has) pending_codes.push_back(res);
      end
    end

    // Random streams: noisy texture, flat patches that produce ties, and hard edges.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_reg(mct_pkg::REG_IMAGE_WIDTH, phases[ph].width);
      write_reg(mct_pkg::REG_IMAGE_HEIGHT, phases[ph].height);
      set_idle(phases[ph].idle);
      for (int i = 0; i < phases[ph].items; i++) begin
        // Hold the sender until the block has drained.
        if (phases[ph].hold_off && i == phases[ph].items / 2) settle_idle();
        r = $urandom_range(99);
        if (r < 50) begin
          p = mct_pkg::pix_t'($urandom_range(255));
        end else if (r < 80) begin
          if ($urandom_range(15) == 0) flat_level = $urandom_range(253);
          p = mct_pkg::pix_t'(flat_level + $urandom_range(2));
        end else begin
          p = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        drive_pixel(p);
        if (census_predict(p, res)) pending_codes.push_back(res);
      end
    end

    settle_idle();
    if (mismatch_count == 0 && pending_codes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mct_pkg.sv
hdl/mct_pixel_if.sv
hdl/mct_census_if.sv
hdl/mct_cfg_if.sv
hdl/modified_census_transform_3x3.sv
sim/tb.sv
